@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RMQ_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);
`else
`define RMQ_ASSERT(lbl, clk, rstn, prop)
`define RMQ_ASSERT_MSG(lbl, clk, rstn, prop, msg)
`endif
`endif

@@ src/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Types, widths and step functions of the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned ELEM_BITS = 16;
  localparam int unsigned FRAC_BITS = ELEM_BITS - 2;
  localparam int unsigned TW        = ELEM_BITS + 3;
  localparam int unsigned RAD_W     = 2 * ELEM_BITS - 1;
  localparam int unsigned RES_W     = RAD_W + 1;
  localparam int unsigned ROOT_W    = ELEM_BITS;
  localparam int unsigned MAG_W     = ELEM_BITS + 1;
  localparam int unsigned DIVD_W    = 2 * ELEM_BITS;
  localparam int unsigned DEN_W     = ELEM_BITS + 1;
  localparam int unsigned CMP_W     = DEN_W + ELEM_BITS;

  localparam int unsigned SQ_PER_STAGE  = 2;
  localparam int unsigned SQ_STAGES     = (ROOT_W + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
  localparam int unsigned DIV_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES    = (ELEM_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int unsigned LANE_LAT      = DIV_STAGES + 1;
  localparam int unsigned LATENCY       = SQ_STAGES + DIV_STAGES + 3;

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic signed [TW-1:0]        wide_t;

  typedef enum logic [1:0] {
    DOM_W = 2'd0,
    DOM_X = 2'd1,
    DOM_Y = 2'd2,
    DOM_Z = 2'd3
  } dom_e;

  typedef struct packed {
    elem_t m00; elem_t m01; elem_t m02;
    elem_t m10; elem_t m11; elem_t m12;
    elem_t m20; elem_t m21; elem_t m22;
  } req_t;

  typedef struct packed {
    elem_t quat_w;
    elem_t quat_x;
    elem_t quat_y;
    elem_t quat_z;
    logic  degenerate;
  } rsp_t;

  // Sideband of one request: branch, flag and the three numerator lanes
  typedef struct packed {
    dom_e                  dom;
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [RAD_W-1:0] rad;
  } front_t;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RES_W-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [DIVD_W-1:0]    rem;
    logic [ELEM_BITS-1:0] quo;
  } div_t;

  // One digit of the bitwise square root, step j from the top
  function automatic sq_t sq_step(sq_t s, int unsigned j);
    logic [RES_W-1:0] bitv;
    logic [RES_W-1:0] trial;
    sq_t              o;
    bitv  = RES_W'(1) << (2 * (ROOT_W - 1 - j));
    trial = s.res + bitv;
    o     = s;
    if ({1'b0, s.rem} >= trial) begin
      o.rem = s.rem - trial[RAD_W-1:0];
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // One quotient bit of the restoring divider, step j from the top
  function automatic div_t div_step(div_t s, logic [DEN_W-1:0] den, int unsigned j);
    logic [CMP_W-1:0] sh;
    div_t             o;
    sh = CMP_W'(den) << (ELEM_BITS - 1 - j);
    o  = s;
    if (CMP_W'(s.rem) >= sh) begin
      o.rem = s.rem - sh[DIVD_W-1:0];
      o.quo = s.quo | (ELEM_BITS'(1) << (ELEM_BITS - 1 - j));
    end
    return o;
  endfunction

endpackage

@@ src/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// Branch selection, radicand and numerator magnitudes, one register stage.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rmq_pkg::req_t     req_i,
  output logic              valid_o,
  output rmq_pkg::front_t   front_o
);
  import rmq_pkg::*;

  wide_t  w00, w01, w02, w10, w11, w12, w20, w21, w22;
  wide_t  tr, a_val, a_full;
  wide_t  num [3];
  wide_t  absn [3];
  dom_e   dom;
  logic   valid_q;
  front_t front_d, front_q;

  assign w00 = wide_t'(req_i.m00);
  assign w01 = wide_t'(req_i.m01);
  assign w02 = wide_t'(req_i.m02);
  assign w10 = wide_t'(req_i.m10);
  assign w11 = wide_t'(req_i.m11);
  assign w12 = wide_t'(req_i.m12);
  assign w20 = wide_t'(req_i.m20);
  assign w21 = wide_t'(req_i.m21);
  assign w22 = wide_t'(req_i.m22);
  assign tr  = w00 + w11 + w22;

  always_comb begin
    // strict compares: ties fall through to the next branch
    if (tr > 0)                      dom = DOM_W;
    else if (w00 > w11 && w00 > w22) dom = DOM_X;
    else if (w11 > w22)              dom = DOM_Y;
    else                             dom = DOM_Z;

    unique case (dom)
      DOM_W: begin
        a_val  = tr;
        num[0] = w21 - w12; num[1] = w02 - w20; num[2] = w10 - w01;
      end
      DOM_X: begin
        a_val  = w00 - w11 - w22;
        num[0] = w21 - w12; num[1] = w01 + w10; num[2] = w02 + w20;
      end
      DOM_Y: begin
        a_val  = w11 - w00 - w22;
        num[0] = w02 - w20; num[1] = w01 + w10; num[2] = w12 + w21;
      end
      default: begin
        a_val  = w22 - w00 - w11;
        num[0] = w10 - w01; num[1] = w02 + w20; num[2] = w12 + w21;
      end
    endcase

    a_full = a_val + (wide_t'(1) <<< FRAC_BITS);

    front_d.side.dom   = dom;
    front_d.side.degen = a_full[TW-1] || (a_full == '0);
    front_d.rad        = front_d.side.degen ? '0
                       : {a_full[RAD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    for (int l = 0; l < 3; l++) begin
      front_d.side.neg[l] = num[l][TW-1];
      absn[l]             = num[l][TW-1] ? -num[l] : num[l];
      front_d.side.mag[l] = absn[l][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign valid_o = valid_q;
  assign front_o = front_q;

endmodule

@@ src/rmq_isqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_isqrt
// Pipelined bitwise integer square root, sideband carried alongside.
// ----------------------------------------------------------------------------
module rmq_isqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  rmq_pkg::front_t                    front_i,
  output logic                               valid_o,
  output logic [rmq_pkg::ROOT_W-1:0]         root_o,
  output rmq_pkg::side_t                     side_o
);
  import rmq_pkg::*;

  logic  valid_q  [SQ_STAGES];
  sq_t   sq_q     [SQ_STAGES];
  side_t side_q   [SQ_STAGES];
  sq_t   sq_in    [SQ_STAGES];
  sq_t   sq_d     [SQ_STAGES];
  logic  valid_in [SQ_STAGES];
  side_t side_in  [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign sq_in[s]    = '{rem: front_i.rad, res: '0};
      assign valid_in[s] = valid_i;
      assign side_in[s]  = front_i.side;
    end else begin : g_next
      assign sq_in[s]    = sq_q[s-1];
      assign valid_in[s] = valid_q[s-1];
      assign side_in[s]  = side_q[s-1];
    end

    always_comb begin
      sq_d[s] = sq_in[s];
      for (int j = 0; j < SQ_PER_STAGE; j++) begin
        if (s * SQ_PER_STAGE + j < ROOT_W) begin
          sq_d[s] = sq_step(sq_d[s], s * SQ_PER_STAGE + j);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[s]   <= sq_d[s];
      side_q[s] <= side_in[s];
    end
  end

  assign valid_o = valid_q[SQ_STAGES-1];
  assign root_o  = sq_q[SQ_STAGES-1].res[ROOT_W-1:0];
  assign side_o  = side_q[SQ_STAGES-1];

endmodule

@@ src/rmq_div_lane.sv @@
// ----------------------------------------------------------------------------
// rmq_div_lane
// One numerator lane: rounded n * 2^F / (2R) by a pipelined restoring divider.
// ----------------------------------------------------------------------------
module rmq_div_lane (
  input  logic                          clk_i,
  input  logic [rmq_pkg::MAG_W-1:0]     mag_i,
  input  logic                          neg_i,
  input  logic [rmq_pkg::ROOT_W-1:0]    root_i,
  output logic [rmq_pkg::ELEM_BITS-1:0] quo_o,
  output logic                          ovf_o,
  output logic                          neg_o
);
  import rmq_pkg::*;

  logic [DIVD_W-1:0] divd;
  logic [DEN_W-1:0]  den;
  logic              ovf;

  div_t              dv_q   [LANE_LAT];
  logic [DEN_W-1:0]  den_q  [LANE_LAT];
  logic              ovf_q  [LANE_LAT];
  logic              neg_q  [LANE_LAT];
  div_t              dv_d   [LANE_LAT];

  // add R for round half up, quotient of 2^ELEM_BITS or more saturates anyway
  assign divd = (DIVD_W'(mag_i) << FRAC_BITS) + DIVD_W'(root_i);
  assign den  = DEN_W'(root_i) << 1;
  assign ovf  = CMP_W'(divd) >= (CMP_W'(den) << ELEM_BITS);

  assign dv_d[0] = '{rem: divd, quo: '0};

  for (genvar s = 1; s < LANE_LAT; s++) begin : g_stage
    always_comb begin
      dv_d[s] = dv_q[s-1];
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        if ((s - 1) * DIV_PER_STAGE + j < ELEM_BITS) begin
          dv_d[s] = div_step(dv_d[s], den_q[s-1], (s - 1) * DIV_PER_STAGE + j);
        end
      end
    end
  end

  for (genvar s = 0; s < LANE_LAT; s++) begin : g_reg
    if (s == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        dv_q[s]  <= dv_d[s];
        den_q[s] <= den;
        ovf_q[s] <= ovf;
        neg_q[s] <= neg_i;
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        dv_q[s]  <= dv_d[s];
        den_q[s] <= den_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign quo_o = dv_q[LANE_LAT-1].quo;
  assign ovf_o = ovf_q[LANE_LAT-1];
  assign neg_o = neg_q[LANE_LAT-1];

endmodule

@@ src/rotation_matrix_to_quaternion_unit.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix (3x3, Q2.14) to unit quaternion by Shepperd's method.
// ----------------------------------------------------------------------------
// A request is taken on any cycle with start_i high; busy_o is always low, so
// one matrix can enter every clock. Each request returns one result on rsp_o,
// marked by a one-cycle done_o pulse, in request order. The result is never
// held: sample it in that cycle.
// The path is the 16-digit square root (two digits per stage, 8 stages)
// and the 16-bit restoring divide (three bits per stage, 6 stages plus setup),
// with one input and one output register.

`include "assert_macros.svh"

module rotation_matrix_to_quaternion_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  rmq_pkg::req_t req_i,
  output logic          done_o,
  output rmq_pkg::rsp_t rsp_o
);
  import rmq_pkg::*;

  localparam elem_t MAX_P = elem_t'((1 << (ELEM_BITS - 1)) - 1);
  localparam elem_t MIN_N = elem_t'(1 << (ELEM_BITS - 1));

  logic              fr_valid;
  front_t            fr;
  logic              sq_valid;
  logic [ROOT_W-1:0] root;
  side_t             sq_side;
  logic [ROOT_W:0]   root_inc;

  logic [ELEM_BITS-1:0] lane_quo [3];
  logic                 lane_ovf [3];
  logic                 lane_neg [3];
  elem_t                lane_val [3];

  logic  vld_q  [LANE_LAT];
  dom_e  dom_q  [LANE_LAT];
  logic  dgn_q  [LANE_LAT];
  elem_t dval_q [LANE_LAT];

  elem_t comp [4];
  rsp_t  rsp_d, rsp_q;
  logic  done_q;

  assign busy_o = 1'b0;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .req_i   (req_i),
    .valid_o (fr_valid),
    .front_o (fr)
  );

  rmq_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .front_i (fr),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    rmq_div_lane u_lane (
      .clk_i  (clk_i),
      .mag_i  (sq_side.mag[l]),
      .neg_i  (sq_side.neg[l]),
      .root_i (root),
      .quo_o  (lane_quo[l]),
      .ovf_o  (lane_ovf[l]),
      .neg_o  (lane_neg[l])
    );

    always_comb begin
      if (!lane_neg[l]) begin
        lane_val[l] = (lane_ovf[l] || lane_quo[l][ELEM_BITS-1]) ? MAX_P
                    : elem_t'(lane_quo[l]);
      end else if (lane_ovf[l] ||
                   (lane_quo[l][ELEM_BITS-1] && (lane_quo[l][ELEM_BITS-2:0] != '0))) begin
        lane_val[l] = MIN_N;
      end else begin
        lane_val[l] = -elem_t'(lane_quo[l]);
      end
    end
  end

  // dominant component is S/4 rounded half up
  assign root_inc = {1'b0, root} + 1'b1;

  for (genvar s = 0; s < LANE_LAT; s++) begin : g_side
    if (s == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[s] <= 1'b0;
        end else begin
          vld_q[s] <= sq_valid;
        end
      end

      always_ff @(posedge clk_i) begin
        dom_q[s]  <= sq_side.dom;
        dgn_q[s]  <= sq_side.degen;
        dval_q[s] <= elem_t'(root_inc[ROOT_W:1]);
      end
    end else begin : g_tail
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[s] <= 1'b0;
        end else begin
          vld_q[s] <= vld_q[s-1];
        end
      end

      always_ff @(posedge clk_i) begin
        dom_q[s]  <= dom_q[s-1];
        dgn_q[s]  <= dgn_q[s-1];
        dval_q[s] <= dval_q[s-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dgn_q[LANE_LAT-1]) begin
        comp[k] = '0;
      end else if (k == int'(dom_q[LANE_LAT-1])) begin
        comp[k] = dval_q[LANE_LAT-1];
      end else if (k < int'(dom_q[LANE_LAT-1])) begin
        comp[k] = lane_val[k];
      end else begin
        comp[k] = lane_val[k-1];
      end
    end
    rsp_d.quat_w     = comp[0];
    rsp_d.quat_x     = comp[1];
    rsp_d.quat_y     = comp[2];
    rsp_d.quat_z     = comp[3];
    rsp_d.degenerate = dgn_q[LANE_LAT-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `RMQ_ASSERT(a_req_returns, clk_i, rst_ni, start_i |-> ##LATENCY done_o)
  `RMQ_ASSERT(a_no_spurious, clk_i, rst_ni, !start_i |-> ##LATENCY !done_o)
  `RMQ_ASSERT_MSG(a_degen_zero, clk_i, rst_ni,
    (done_o && rsp_o.degenerate) |-> (rsp_o.quat_w == '0 && rsp_o.quat_x == '0 &&
    rsp_o.quat_y == '0 && rsp_o.quat_z == '0), "degenerate result not zero")
  `RMQ_ASSERT_MSG(a_dom_positive, clk_i, rst_ni,
    (done_o && !rsp_o.degenerate) |-> (rsp_o.quat_w > 0 || rsp_o.quat_x > 0 ||
    rsp_o.quat_y > 0 || rsp_o.quat_z > 0), "no positive dominant component")

endmodule
